[rtl/vtc_pkg.sv]
// Package for the VFO tuning controller: widths, reset values, register indexes, states.
package vtc_pkg;

  localparam int FREQ_W      = 32;
  localparam int STEP_W      = 27;
  localparam int COUNT_W     = 6;
  localparam int OFFSET_W    = 25;
  localparam int TONE_W      = 6;
  localparam int BIT_CNT_W   = $clog2(FREQ_W);
  localparam int CFG_IDX_W   = 2;
  localparam int S_DATA_W    = 72;
  localparam int M_DATA_W    = 72;

  localparam int TONE_COUNT_DEF = 50;

  localparam logic [FREQ_W-1:0] FREQ_MIN_RST  = 32'd144000000;
  localparam logic [FREQ_W-1:0] FREQ_MAX_RST  = 32'd146000000;
  localparam logic [STEP_W-1:0] TUNE_STEP_RST = 27'd12500;
  localparam logic [STEP_W-1:0] ALIGN_LIMIT   = 27'd1000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FREQ_MIN  = 2'd0,
    REG_FREQ_MAX  = 2'd1,
    REG_TUNE_STEP = 2'd2
  } vtc_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SET_LO,
    ST_SET_HI,
    ST_TONE,
    ST_DIV,
    ST_ALIGN,
    ST_ADD,
    ST_CMP_HI,
    ST_CMP_LO,
    ST_WRAP1,
    ST_WRAP2,
    ST_WRAP3,
    ST_OFS,
    ST_OUT
  } vtc_state_t;

endpackage

[rtl/vfo_tuning_controller_unit.sv]
// VFO tuning controller top level: sequencer around one shared 32-bit add/subtract unit.
//
// Input channel s_*: one item per knob or key event. s_tuser carries req_type
// (1 set frequency, 0 tune). s_tready is high only while the sequencer is idle.
// Output channel m_*: one result item per input item, held in an output
// register until taken; the next input item is accepted while it waits.
// Configuration channel cfg_*: always ready; index 0 freq_min, 1 freq_max,
// 2 tune_step; other indexes are ignored. Write only while idle.
// A frequency tune item first takes the remainder for step alignment (only for
// a nonzero step below ALIGN_LIMIT) by a restoring divide that takes one bit
// per cycle through the shared unit, followed by the alignment subtract, the
// add, up to two band compares, three wrap steps when out of band and the
// offset add, all on the same unit.
// A tone item walks the index into range one add or subtract per cycle.
// A new input item is taken only once the previous result has left the sequencer.
// Reset (rst, synchronous) loads the default limits and step, sets the
// receive frequency to the lower default limit and the tone index to zero,
// and empties the output register. If the receiver stalls, the finished
// result stays in the sequencer until the output register is free.
module vfo_tuning_controller_unit #(
  parameter int TONE_COUNT = vtc_pkg::TONE_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [5:0] step_count, [37:6] new_frequency, [38] tone_mode, [39] reverse,
  // [64:40] duplex_offset, [71:65] zero
  input  logic [vtc_pkg::S_DATA_W-1:0]    s_tdata,
  // [0] req_type
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [31:0] rx_out, [63:32] tx_out, [69:64] tone_out, [70] tone_on, [71] zero
  output logic [vtc_pkg::M_DATA_W-1:0]    m_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [vtc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vtc_pkg::FREQ_W-1:0]      cfg_data
);

  localparam int FW = vtc_pkg::FREQ_W;
  localparam int SW = vtc_pkg::STEP_W;
  localparam logic signed [7:0] TC_S = 8'(TONE_COUNT);

  vtc_pkg::vtc_state_t state, state_next;

  logic [FW-1:0]                      freq_min, freq_max;
  logic [SW-1:0]                      tune_step;
  logic [FW-1:0]                      stored_rx;
  logic [vtc_pkg::TONE_W-1:0]         tone_index;

  logic [FW-1:0]                      f, rem, dvd, prod, shifted;
  logic [vtc_pkg::BIT_CNT_W-1:0]      bit_cnt;
  logic signed [7:0]                  tone_v;
  logic [vtc_pkg::OFFSET_W-1:0]       offset;
  logic                               rev, tmode, wrap_hi;

  logic [FW-1:0]                      m_rx, m_tx;
  logic [vtc_pkg::TONE_W-1:0]         m_tone;
  logic                               m_tone_on;

  logic [FW-1:0]                      alu_a, alu_b;
  logic                               alu_sub;
  logic [FW:0]                        alu_res;
  logic                               borrow;

  logic signed [vtc_pkg::COUNT_W-1:0] s_count;
  logic [FW-1:0]                      s_freq;
  logic signed [FW+1:0]               prod_full;
  logic                               s_acc, m_free;

  assign s_count   = $signed(s_tdata[5:0]);
  assign s_freq    = s_tdata[37:6];
  assign prod_full = s_count * $signed({1'b0, tune_step});
  assign s_acc     = s_tvalid && s_tready;
  assign m_free    = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;

  assign alu_res = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b}) : ({1'b0, alu_a} + {1'b0, alu_b});
  assign borrow  = alu_res[FW];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vtc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    alu_a      = f;
    alu_b      = '0;
    alu_sub    = 1'b0;
    case (state)
      vtc_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (s_tuser) begin
            state_next = vtc_pkg::ST_SET_LO;
          end else if (s_tdata[38]) begin
            state_next = vtc_pkg::ST_TONE;
          end else if (tune_step != '0 && tune_step < vtc_pkg::ALIGN_LIMIT) begin
            state_next = vtc_pkg::ST_DIV;
          end else begin
            state_next = vtc_pkg::ST_ADD;
          end
        end
      end
      vtc_pkg::ST_SET_LO: begin
        alu_b   = freq_min;
        alu_sub = 1'b1;
        state_next = borrow ? vtc_pkg::ST_OFS : vtc_pkg::ST_SET_HI;
      end
      vtc_pkg::ST_SET_HI: begin
        alu_a   = freq_max;
        alu_b   = f;
        alu_sub = 1'b1;
        state_next = vtc_pkg::ST_OFS;
      end
      vtc_pkg::ST_TONE: begin
        if (tone_v >= 0 && tone_v < TC_S) begin
          state_next = vtc_pkg::ST_OFS;
        end
      end
      vtc_pkg::ST_DIV: begin
        alu_a   = {rem[FW-2:0], dvd[FW-1]};
        alu_b   = FW'(tune_step);
        alu_sub = 1'b1;
        if (bit_cnt == vtc_pkg::BIT_CNT_W'(FW - 1)) begin
          state_next = vtc_pkg::ST_ALIGN;
        end
      end
      vtc_pkg::ST_ALIGN: begin
        alu_b   = rem;
        alu_sub = 1'b1;
        state_next = vtc_pkg::ST_ADD;
      end
      vtc_pkg::ST_ADD: begin
        alu_b = prod;
        state_next = vtc_pkg::ST_CMP_HI;
      end
      vtc_pkg::ST_CMP_HI: begin
        alu_a   = freq_max;
        alu_b   = f;
        alu_sub = 1'b1;
        state_next = borrow ? vtc_pkg::ST_WRAP1 : vtc_pkg::ST_CMP_LO;
      end
      vtc_pkg::ST_CMP_LO: begin
        alu_b   = freq_min;
        alu_sub = 1'b1;
        state_next = borrow ? vtc_pkg::ST_WRAP1 : vtc_pkg::ST_OFS;
      end
      vtc_pkg::ST_WRAP1: begin
        alu_a   = wrap_hi ? f : freq_max;
        alu_b   = wrap_hi ? freq_max : f;
        alu_sub = 1'b1;
        state_next = vtc_pkg::ST_WRAP2;
      end
      vtc_pkg::ST_WRAP2: begin
        alu_b = freq_min;
        state_next = vtc_pkg::ST_WRAP3;
      end
      vtc_pkg::ST_WRAP3: begin
        alu_b   = FW'(tune_step);
        alu_sub = 1'b1;
        state_next = vtc_pkg::ST_OFS;
      end
      vtc_pkg::ST_OFS: begin
        alu_b = {{(FW - vtc_pkg::OFFSET_W){offset[vtc_pkg::OFFSET_W-1]}}, offset};
        state_next = vtc_pkg::ST_OUT;
      end
      vtc_pkg::ST_OUT: begin
        if (m_free) begin
          state_next = vtc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = vtc_pkg::ST_IDLE;
      end
    endcase
  end

  // config and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      freq_min   <= vtc_pkg::FREQ_MIN_RST;
      freq_max   <= vtc_pkg::FREQ_MAX_RST;
      tune_step  <= vtc_pkg::TUNE_STEP_RST;
      stored_rx  <= vtc_pkg::FREQ_MIN_RST;
      tone_index <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          vtc_pkg::REG_FREQ_MIN:  freq_min  <= cfg_data;
          vtc_pkg::REG_FREQ_MAX:  freq_max  <= cfg_data;
          vtc_pkg::REG_TUNE_STEP: tune_step <= cfg_data[SW-1:0];
          default: ;
        endcase
      end
      if (state == vtc_pkg::ST_OFS) begin
        stored_rx <= f;
      end
      if (state == vtc_pkg::ST_TONE && tone_v >= 0 && tone_v < TC_S) begin
        tone_index <= tone_v[vtc_pkg::TONE_W-1:0];
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      vtc_pkg::ST_IDLE: begin
        if (s_acc) begin
          f       <= s_tuser ? s_freq : stored_rx;
          dvd     <= stored_rx;
          rem     <= '0;
          bit_cnt <= '0;
          prod    <= prod_full[FW-1:0];
          tone_v  <= $signed({2'b00, tone_index}) + 8'(s_count);
          tmode   <= s_tdata[38];
          rev     <= s_tdata[39];
          offset  <= s_tdata[64:40];
        end
      end
      vtc_pkg::ST_SET_LO: begin
        if (borrow) begin
          f <= freq_min;
        end
      end
      vtc_pkg::ST_SET_HI: begin
        if (borrow) begin
          f <= freq_max;
        end
      end
      vtc_pkg::ST_TONE: begin
        if (tone_v < 0) begin
          tone_v <= tone_v + TC_S;
        end else if (tone_v >= TC_S) begin
          tone_v <= tone_v - TC_S;
        end
      end
      vtc_pkg::ST_DIV: begin
        rem     <= borrow ? alu_a : alu_res[FW-1:0];
        dvd     <= {dvd[FW-2:0], 1'b0};
        bit_cnt <= bit_cnt + 1'b1;
      end
      vtc_pkg::ST_ALIGN, vtc_pkg::ST_ADD,
      vtc_pkg::ST_WRAP1, vtc_pkg::ST_WRAP2, vtc_pkg::ST_WRAP3: begin
        f <= alu_res[FW-1:0];
      end
      vtc_pkg::ST_CMP_HI: begin
        wrap_hi <= borrow;
      end
      vtc_pkg::ST_OFS: begin
        shifted <= alu_res[FW-1:0];
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == vtc_pkg::ST_OUT && m_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == vtc_pkg::ST_OUT && m_free) begin
      m_rx      <= rev ? shifted : f;
      m_tx      <= rev ? f : shifted;
      m_tone    <= tone_index;
      m_tone_on <= tmode;
    end
  end

  assign m_tdata = {1'b0, m_tone_on, m_tone, m_tx, m_rx};

  a_tone_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, tone_index} < 7'(TONE_COUNT))
    else $error("tone index outside ring");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("item accepted while sequencer busy");

  a_rem_below_step: assert property (@(posedge clk) disable iff (rst)
    state == vtc_pkg::ST_DIV |-> rem < FW'(tune_step))
    else $error("partial remainder not below step");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    state == vtc_pkg::ST_OUT && m_tvalid && !m_tready |=> state == vtc_pkg::ST_OUT)
    else $error("result released while output register full");

endmodule

[tb/vfo_tuning_controller_unit_tb.sv]
// Self-checking testbench for vfo_tuning_controller_unit with a built-in predictor.
module vfo_tuning_controller_unit_tb;

  localparam int TONES = vtc_pkg::TONE_COUNT_DEF;
  localparam logic [31:0] ALIGN_HZ = {5'd0, vtc_pkg::ALIGN_LIMIT};

  typedef struct packed {
    logic               is_set;
    logic signed [5:0]  count;
    logic [31:0]        freq;
    logic               tone_mode;
    logic               reverse;
    logic signed [24:0] offset;
  } knob_item_t;

  typedef struct packed {
    logic [31:0] rx;
    logic [31:0] tx;
    logic [5:0]  tone;
    logic        tone_on;
  } vfo_result_t;

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [vtc_pkg::S_DATA_W-1:0]   s_tdata;
  logic                           s_tuser;
  logic                           m_tvalid;
  logic                           m_tready;
  logic [vtc_pkg::M_DATA_W-1:0]   m_tdata;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [vtc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [vtc_pkg::FREQ_W-1:0]     cfg_data;

  // predictor state and register copies
  logic [31:0] rx_freq;
  logic [5:0]  tone_idx;
  logic [31:0] band_lo;
  logic [31:0] band_hi;
  logic [26:0] step_hz;

  vfo_result_t pending_results[$];
  vfo_result_t expected_now;
  int          mismatches = 0;
  bit          gaps_on = 1'b0;
  bit          stalls_on = 1'b0;
  int          burst_left = 0;
  int          rdy_cyc = 0;
  logic [15:0] stall_pat = '1;

  vfo_tuning_controller_unit #(.TONE_COUNT(TONES)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  function automatic vfo_result_t apply_knob_item(knob_item_t it);
    vfo_result_t r;
    logic [31:0] f, st, ofs, shifted, nn;
    int n, m;
    st = {5'd0, step_hz};
    n = int'(it.count);
    if (it.is_set) begin
      if (it.freq < band_lo) rx_freq = band_lo;
      else if (it.freq > band_hi) rx_freq = band_hi;
      else rx_freq = it.freq;
    end else if (it.tone_mode) begin
      m = n % TONES;
      if (m < 0) m += TONES;
      tone_idx = 6'((int'(tone_idx) + m) % TONES);
    end else begin
      f = rx_freq;
      if (st != 0 && st < ALIGN_HZ) f = f - (f % st);
      nn = 32'(n);
      f = f + nn * st;
      if (f > band_hi) f = band_lo + f - band_hi - st;
      else if (f < band_lo) f = band_hi - (f - band_lo) - st;
      rx_freq = f;
    end
    ofs = {{7{it.offset[24]}}, it.offset};
    shifted = rx_freq + ofs;
    r.rx = it.reverse ? shifted : rx_freq;
    r.tx = it.reverse ? rx_freq : shifted;
    r.tone = tone_idx;
    r.tone_on = it.tone_mode;
    return r;
  endfunction

  function automatic knob_item_t mk_item(bit set, int cnt, logic [31:0] nf, bit tm, bit rev,
                                         int ofs);
    knob_item_t it;
    it.is_set = set;
    it.count = 6'(cnt);
    it.freq = nf;
    it.tone_mode = tm;
    it.reverse = rev;
    it.offset = 25'(ofs);
    return it;
  endfunction

  function automatic logic [31:0] pick_freq();
    logic [31:0] d, lo, hi;
    d = ($urandom_range(0, 1) == 1) ? 32'($urandom_range(0, 2000))
                                     : {5'd0, step_hz} * 32'($urandom_range(0, 3));
    lo = (band_lo < band_hi) ? band_lo : band_hi;
    hi = (band_lo < band_hi) ? band_hi : band_lo;
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return band_lo - d;
      2: return band_hi + d;
      3: return band_hi - d;
      4: return band_lo + d;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  function automatic int pick_offset();
    case ($urandom_range(0, 9))
      0: return 10000000;
      1: return -10000000;
      default: return int'($urandom_range(0, 20000000)) - 10000000;
    endcase
  endfunction

  function automatic knob_item_t rand_item();
    int k, cnt;
    k = $urandom_range(0, 99);
    cnt = int'($urandom_range(0, 32)) - 16;
    if (k < 25)
      return mk_item(1'b1, cnt, pick_freq(), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), pick_offset());
    if (k < 60)
      return mk_item(1'b0, cnt, $urandom, 1'b0, 1'($urandom_range(0, 1)), pick_offset());
    if (k < 85)
      return mk_item(1'b0, cnt, $urandom, 1'b1, 1'($urandom_range(0, 1)), pick_offset());
    return mk_item(1'($urandom_range(0, 1)), cnt, $urandom, 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), pick_offset());
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < 40)
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // called at a rising edge; leaves tvalid high unless a gap follows
  task automatic send_item(knob_item_t it);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser <= it.is_set;
    s_tdata <= {7'd0, it.offset, it.reverse, it.tone_mode, it.freq, it.count};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(apply_knob_item(it));
    if (gaps_on) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 6);
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(0, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(vtc_pkg::vtc_reg_t idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      vtc_pkg::REG_FREQ_MIN: band_lo = val;
      vtc_pkg::REG_FREQ_MAX: band_hi = val;
      vtc_pkg::REG_TUNE_STEP: step_hz = val[26:0];
      default: ;
    endcase
  endtask

  task automatic set_band(logic [31:0] lo, logic [31:0] hi, logic [31:0] st);
    wait_drain();
    write_reg(vtc_pkg::REG_FREQ_MIN, lo);
    write_reg(vtc_pkg::REG_FREQ_MAX, hi);
    write_reg(vtc_pkg::REG_TUNE_STEP, st);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_state();
    send_item(mk_item(1'b0, 0, 32'h0, 1'b0, 1'b0, 600000));
    send_item(mk_item(1'b0, 0, 32'hFFFFFFFF, 1'b0, 1'b1, -600000));
    send_item(mk_item(1'b1, 0, 32'h0, 1'b0, 1'b0, -10000000));
    send_item(mk_item(1'b1, 0, 32'hFFFFFFFF, 1'b0, 1'b1, 10000000));
    send_item(mk_item(1'b1, 0, 32'd145006000, 1'b0, 1'b0, 0));
    send_item(mk_item(1'b0, 1, 32'h0, 1'b0, 1'b0, 0));
    send_item(mk_item(1'b0, 16, 32'h0, 1'b0, 1'b1, 5000000));
    send_item(mk_item(1'b0, -16, 32'h0, 1'b0, 1'b0, -5000000));
  endtask

  task automatic test_band_wrap();
    send_item(mk_item(1'b1, 0, 32'd146000000, 1'b0, 1'b0, 0));
    send_item(mk_item(1'b0, 1, 32'h0, 1'b0, 1'b0, 0));
    send_item(mk_item(1'b1, 0, 32'd144000000, 1'b0, 1'b0, 0));
    send_item(mk_item(1'b0, -1, 32'h0, 1'b0, 1'b1, 600000));
  endtask

  task automatic test_tone_ring();
    repeat (4) send_item(mk_item(1'b0, 16, 32'h0, 1'b1, 1'b0, 0));
    send_item(mk_item(1'b0, -16, 32'h0, 1'b1, 1'b1, 100));
    send_item(mk_item(1'b0, 0, 32'h0, 1'b1, 1'b0, 0));
    send_item(mk_item(1'b1, -16, 32'd145500000, 1'b1, 1'b0, 0));
  endtask

  task automatic test_edge_settings();
    // lower limit above upper limit
    set_band(32'd146000000, 32'd144000000, 32'd5000);
    send_item(mk_item(1'b1, 0, 32'd145000000, 1'b0, 1'b0, 0));
    send_item(mk_item(1'b1, 0, 32'hFFFFFFFF, 1'b0, 1'b0, 0));
    // zero step leaves only the band wrap
    set_band(32'd144000000, 32'd146000000, 32'd0);
    send_item(mk_item(1'b0, 5, 32'h0, 1'b0, 1'b0, 0));
    send_item(mk_item(1'b0, -3, 32'h0, 1'b0, 1'b1, 1000));
    // step at the alignment limit: no alignment
    set_band(32'd144000000, 32'd146000000, 32'd1000000);
    send_item(mk_item(1'b1, 0, 32'd144123457, 1'b0, 1'b0, 0));
    send_item(mk_item(1'b0, 1, 32'h0, 1'b0, 1'b0, 0));
  endtask

  task automatic test_random_sweep();
    logic [31:0] lo_tab[10] = '{32'd144000000, 32'd0, 32'd0, 32'd430000000, 32'd146000000,
                                32'd7000000, 32'd7000000, 32'd100, 32'd144000000,
                                32'hFFFF0000};
    logic [31:0] hi_tab[10] = '{32'd146000000, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd440000000,
                                32'd144000000, 32'd7300000, 32'd7300000, 32'd100,
                                32'd146000000, 32'hFFFFFFF0};
    logic [31:0] st_tab[10] = '{32'd12500, 32'd1, 32'd100000000, 32'd25000, 32'd5000,
                                32'd999999, 32'd1000000, 32'd7, 32'd0, 32'd37};
    for (int p = 0; p < 13; p++) begin
      if (p < 10) begin
        set_band(lo_tab[p], hi_tab[p], st_tab[p]);
      end else begin
        set_band($urandom, $urandom, $urandom_range(1, 100000000));
      end
      gaps_on = (p % 3) != 0;
      stalls_on = (p % 4) != 1;
      repeat ((p < 10) ? 80 : 35) send_item(rand_item());
    end
  endtask

  always @(posedge clk) begin
    rdy_cyc <= rdy_cyc + 1;
    if (rdy_cyc % 64 == 0)
      stall_pat <= !stalls_on ? 16'hFFFF :
                   ($urandom_range(0, 1) == 1) ? 16'($urandom) : 16'($urandom & $urandom);
    else
      stall_pat <= {stall_pat[0], stall_pat[15:1]};
    m_tready <= stall_pat[0];
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected item rx", m_tdata[31:0], 32'd0);
      end else begin
        expected_now = pending_results.pop_front();
        if (m_tdata[31:0] !== expected_now.rx)
          flag_mismatch("rx_out", m_tdata[31:0], expected_now.rx);
        if (m_tdata[63:32] !== expected_now.tx)
          flag_mismatch("tx_out", m_tdata[63:32], expected_now.tx);
        if (m_tdata[69:64] !== expected_now.tone)
          flag_mismatch("tone_out", 32'(m_tdata[69:64]), 32'(expected_now.tone));
        if (m_tdata[70] !== expected_now.tone_on)
          flag_mismatch("tone_on", 32'(m_tdata[70]), 32'(expected_now.tone_on));
      end
    end
  end

  initial begin
    #5000000;
    $display("vfo_tuning_controller_unit_tb NOT OK");
    $finish;
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = vtc_pkg::REG_FREQ_MIN;
    cfg_data = '0;
    rx_freq = vtc_pkg::FREQ_MIN_RST;
    tone_idx = '0;
    band_lo = vtc_pkg::FREQ_MIN_RST;
    band_hi = vtc_pkg::FREQ_MAX_RST;
    step_hz = vtc_pkg::TUNE_STEP_RST;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_band_wrap();
    test_tone_ring();
    test_edge_settings();
    test_random_sweep();
    wait_drain();
    repeat (60) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("vfo_tuning_controller_unit_tb OK");
    end else begin
      $display("vfo_tuning_controller_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
